// ----- sv/dssf_pkg.sv -----
package dssf_pkg;

    localparam int FRAC_BITS  = 4;
    localparam int MAG_W      = 32;
    // times ten stays below sixteen times the magnitude
    localparam int SCALED_W   = MAG_W + 4;
    localparam int N_W        = SCALED_W - FRAC_BITS;
    localparam int DD_STEPS   = 8;
    localparam int DD_STAGES  = (N_W + DD_STEPS - 1) / DD_STEPS;
    localparam int BIN_W      = DD_STAGES * DD_STEPS;
    localparam int NUM_DIGITS = 8;
    localparam int BCD_W      = NUM_DIGITS * 4;

    localparam logic [SCALED_W-1:0] HALF = (SCALED_W'(1) << FRAC_BITS) >> 1;
    localparam logic [SCALED_W-1:0] TOO_BIG_LIMIT = SCALED_W'(99999999) << FRAC_BITS;

    localparam logic [7:0] SEG_DASH  = 8'h01;
    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    typedef struct packed {
        logic wide;
        logic sgn;
        logic point;
        logic neg;
        logic dash;
    } t_ctrl;

    function automatic logic [7:0] seg_encode(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'h7E;
            4'd1: s = 8'h30;
            4'd2: s = 8'h6D;
            4'd3: s = 8'h79;
            4'd4: s = 8'h33;
            4'd5: s = 8'h5B;
            4'd6: s = 8'h5F;
            4'd7: s = 8'h70;
            4'd8: s = 8'h7F;
            4'd9: s = 8'h73;
            default: s = 8'h7E;
        endcase
        return s;
    endfunction

endpackage

// ----- sv/dssf_bcd_stage.sv -----
module dssf_bcd_stage
    import dssf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_ctrl            i_ctrl,
    input  logic [BIN_W-1:0] i_bin,
    input  logic [BCD_W-1:0] i_bcd,
    output logic             o_valid,
    output t_ctrl            o_ctrl,
    output logic [BIN_W-1:0] o_bin,
    output logic [BCD_W-1:0] o_bcd
);

    logic             r_valid;
    t_ctrl            r_ctrl;
    logic [BIN_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [BIN_W-1:0] n_bin;
    logic [BCD_W-1:0] n_bcd;

    // shift-add-3 steps; digits above the kept eight are dropped (mod 10^8)
    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        for (int s = 0; s < DD_STEPS; s++) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
                if (n_bcd[4*k +: 4] >= 4'd5) begin
                    n_bcd[4*k +: 4] = n_bcd[4*k +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[BIN_W-1]};
            n_bin = {n_bin[BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl <= i_ctrl;
            r_bin  <= n_bin;
            r_bcd  <= n_bcd;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;

endmodule

// ----- sv/decimal_seven_segment_formatter.sv -----
// pipeline from accepted input transaction to output valid: magnitude,
// scale and round, four binary-to-bcd stages, segment encode
// throughput: one transaction per cycle; the whole pipeline holds while the
// output register is full and stalled
// reset: synchronous active-low reset clears all valid bits, data regs are not reset
module decimal_seven_segment_formatter
    import dssf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_value,
    input  logic               i_wide_mode,
    input  logic               i_signed_mode,
    input  logic               i_point_mode,
    input  logic               i_invalid,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_digit_0,
    output logic [7:0]         o_digit_1,
    output logic [7:0]         o_digit_2,
    output logic [7:0]         o_digit_3,
    output logic [7:0]         o_digit_4,
    output logic [7:0]         o_digit_5,
    output logic [7:0]         o_digit_6,
    output logic [7:0]         o_digit_7
);

    logic w_adv;

    // stage a: magnitude
    logic             r_a_valid;
    t_ctrl            r_a_ctrl;
    logic [MAG_W-1:0] r_a_mag;
    logic             n_neg;
    logic [MAG_W-1:0] n_mag;

    // stage b: scale and round
    logic             r_b_valid;
    t_ctrl            r_b_ctrl;
    logic [BIN_W-1:0] r_b_bin;
    logic [SCALED_W-1:0] n_mag_ext;
    logic [SCALED_W-1:0] n_mag10;
    logic [SCALED_W-1:0] n_rounded;
    logic                n_too_big;
    t_ctrl               n_b_ctrl;

    // bcd chain
    logic             w_valid [DD_STAGES+1];
    t_ctrl            w_ctrl  [DD_STAGES+1];
    logic [BIN_W-1:0] w_bin   [DD_STAGES+1];
    logic [BCD_W-1:0] w_bcd   [DD_STAGES+1];

    // output stage
    logic       r_out_valid;
    logic       r_out_wide;
    logic [7:0] r_digit [NUM_DIGITS];
    logic [7:0] n_digit [NUM_DIGITS];

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    always_comb begin
        n_neg = i_value[MAG_W-1];
        n_mag = n_neg ? (~i_value + MAG_W'(1)) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_mag        <= n_mag;
            r_a_ctrl.wide  <= i_wide_mode;
            r_a_ctrl.sgn   <= i_signed_mode;
            r_a_ctrl.point <= i_point_mode;
            r_a_ctrl.neg   <= n_neg;
            r_a_ctrl.dash  <= i_invalid | n_neg;
        end
    end

    always_comb begin
        n_mag_ext = SCALED_W'(r_a_mag);
        n_mag10   = (n_mag_ext << 3) + (n_mag_ext << 1);
        n_rounded = (r_a_ctrl.point ? n_mag10 : n_mag_ext) + HALF;
        // the range check uses ten times the magnitude in both point modes
        n_too_big = !r_a_ctrl.neg && (n_mag10 > TOO_BIG_LIMIT);
        n_b_ctrl  = r_a_ctrl;
        n_b_ctrl.dash = r_a_ctrl.wide & (r_a_ctrl.dash | n_too_big);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_ctrl <= n_b_ctrl;
            r_b_bin  <= BIN_W'(n_rounded[SCALED_W-1:FRAC_BITS]);
        end
    end

    assign w_valid[0] = r_b_valid;
    assign w_ctrl[0]  = r_b_ctrl;
    assign w_bin[0]   = r_b_bin;
    assign w_bcd[0]   = '0;

    for (genvar g = 0; g < DD_STAGES; g++) begin : g_bcd
        dssf_bcd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_ctrl  (w_ctrl[g]),
            .i_bin   (w_bin[g]),
            .i_bcd   (w_bcd[g]),
            .o_valid (w_valid[g+1]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_bin   (w_bin[g+1]),
            .o_bcd   (w_bcd[g+1])
        );
    end

    always_comb begin
        t_ctrl      c;
        logic [7:0] seg;
        c = w_ctrl[DD_STAGES];
        for (int k = 0; k < NUM_DIGITS; k++) begin
            seg = seg_encode(w_bcd[DD_STAGES][4*k +: 4]);
            if (c.point && (k == 1)) begin
                seg = seg | SEG_POINT;
            end
            if (c.wide) begin
                n_digit[k] = c.dash ? SEG_DASH : seg;
            end else if (k >= 4) begin
                n_digit[k] = SEG_BLANK;
            end else if ((k == 3) && c.sgn) begin
                n_digit[k] = c.neg ? SEG_DASH : SEG_BLANK;
            end else begin
                n_digit[k] = seg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[DD_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_wide <= w_ctrl[DD_STAGES].wide;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_digit[k] <= n_digit[k];
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_digit_0 = r_digit[0];
    assign o_digit_1 = r_digit[1];
    assign o_digit_2 = r_digit[2];
    assign o_digit_3 = r_digit[3];
    assign o_digit_4 = r_digit[4];
    assign o_digit_5 = r_digit[5];
    assign o_digit_6 = r_digit[6];
    assign o_digit_7 = r_digit[7];

    a_narrow_upper_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_out_wide) |->
        (o_digit_4 == SEG_BLANK && o_digit_5 == SEG_BLANK &&
         o_digit_6 == SEG_BLANK && o_digit_7 == SEG_BLANK))
        else $error("upper digits not blank in four-digit mode");

    // a dash never comes from the digit table, so dashes come all or none
    a_wide_dash_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_wide && o_digit_0 == SEG_DASH) |->
        (o_digit_1 == SEG_DASH && o_digit_7 == SEG_DASH))
        else $error("partial dash pattern in eight-digit mode");

    a_no_point_digit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_digit_0[7])
        else $error("point lit on digit 0");

    a_hold_stage_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !w_adv) |=> (r_b_valid && $stable(r_b_bin)))
        else $error("stage b transaction lost during stall");

endmodule
